// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/lpr_pkg.sv =====
// ---------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the LRU page replacement cells and top.
// ---------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  // Sized for the largest supported frame count (64 frames).
  localparam int IDX_W  = 6;
  localparam int RANK_W = 6;
  localparam int LIM_W  = RANK_W + 1;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 4;
  localparam int OUT_W  = 56;

  // Search results handed from one cell to the next.
  typedef struct packed {
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic [RANK_W-1:0] worst_rank;
    logic [IDX_W-1:0]  worst_idx;
  } srch_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              clear;
    logic              write;
    logic [IDX_W-1:0]  slot;
    logic [LIM_W-1:0]  limit;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_page_replacement_top.sv =====
// An input beat passes the accept, search and update states in turn; its result
//   beat is registered with the update. A new reference is taken only in the idle
//   state, after the search over the cell chain and the broadcast update of all cells.
// The input is taken again while a result beat still waits on the output.
// Reset: synchronous, active high; empties all frames, zeroes the fault count
//   and sets the frame count to 4. Frame pages are not cleared.
// ---------------------------------------------------------------------------
// lru_page_replacement_top
// Fully associative LRU page-frame tracker built from a chain of frame cells.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_page_replacement_top
  import lpr_pkg::*;
#(
  parameter  int MAX_FRAMES = 8,
  parameter  int PAGE_BITS  = 16,
  localparam int IN_W       = ((PAGE_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // page_number
  input  wire logic             s_tlast,   // last_in_run
  // result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,   // fault, frame_index[3], evicted_valid,
                                           // evicted_page[16], fault_count[32], pad
  // frame count register
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data   // frames_in_use
);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  state_t state;

  // Registered reference under work.
  logic [PAGE_BITS-1:0] ref_page;
  logic                 ref_last;

  // Frame count register and its clamped form (zero acts as one).
  logic [CFG_W-1:0]     frames;
  logic [CFG_W-1:0]     cnt_eff;
  logic [MAX_FRAMES-1:0] active;

  logic [CNT_W-1:0]     faults;

  // Decision captured at the end of the search cycle.
  logic                 dec_hit;
  logic                 dec_write;
  logic                 dec_evict;
  logic [IDX_W-1:0]     dec_slot;
  logic [LIM_W-1:0]     dec_limit;
  logic [PAGE_BITS-1:0] dec_old_page;
  logic [CNT_W-1:0]     dec_count;

  srch_t                chain      [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0] chain_page [0:MAX_FRAMES];
  upd_t                 upd;

  logic                 out_free;
  logic [PAGE_BITS+15:0] old_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign cnt_eff   = (frames == '0) ? CFG_W'(1) : frames;

  // Head of the chain: nothing found yet.
  assign chain[0]      = '0;
  assign chain_page[0] = '0;

  for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
    assign active[gi] = (gi < (1 << CFG_W)) && (CFG_W'(gi) < cnt_eff);

    lpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .INDEX     (gi)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .active         (active[gi]),
      .ref_page       (ref_page),
      .chain_in       (chain[gi]),
      .worst_page_in  (chain_page[gi]),
      .chain_out      (chain[gi+1]),
      .worst_page_out (chain_page[gi+1]),
      .upd            (upd),
      .write_page     (ref_page)
    );
  end

  // Broadcast the update once the result can be placed on the output.
  always_comb begin
    upd.en    = (state == ST_UPDATE) && out_free;
    upd.clear = ref_last;
    upd.write = dec_write;
    upd.slot  = dec_slot;
    upd.limit = dec_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= CFG_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      frames <= cfg_data;
    end
  end

  // Control: accept, search, update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      faults   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid with each update, drop it once the beat is taken.
      if (upd.en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            faults <= ref_last ? '0 : dec_count;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the accepted reference.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ref_page <= s_tdata[PAGE_BITS-1:0];
      ref_last <= s_tlast;
    end
  end

  // Pick the slot from the chain tail: hit, else first empty, else LRU.
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      if (chain[MAX_FRAMES].hit_found) begin
        dec_hit      <= 1'b1;
        dec_write    <= 1'b0;
        dec_evict    <= 1'b0;
        dec_old_page <= '0;
        dec_slot     <= chain[MAX_FRAMES].hit_idx;
        dec_limit    <= {1'b0, chain[MAX_FRAMES].hit_rank};
        dec_count    <= faults;
      end else begin
        dec_hit   <= 1'b0;
        dec_write <= 1'b1;
        dec_count <= (faults == CNT_MAX) ? faults : faults + CNT_W'(1);
        if (chain[MAX_FRAMES].empty_found) begin
          dec_slot     <= chain[MAX_FRAMES].empty_idx;
          dec_limit    <= LIM_W'(MAX_FRAMES);
          dec_evict    <= 1'b0;
          dec_old_page <= '0;
        end else begin
          dec_slot     <= chain[MAX_FRAMES].worst_idx;
          dec_limit    <= {1'b0, chain[MAX_FRAMES].worst_rank};
          dec_evict    <= 1'b1;
          dec_old_page <= chain_page[MAX_FRAMES];
        end
      end
    end
  end

  assign old_ext = {16'b0, dec_old_page};

  // Load the result beat.
  always_ff @(posedge clk) begin
    if (upd.en) begin
      m_tdata <= {3'b000, dec_count, old_ext[15:0], dec_evict, dec_slot[2:0], !dec_hit};
    end
  end

  // The fault count moves only in the update cycle.
  `ASSERT_NEXT(a_faults_hold, clk, rst, state != ST_UPDATE, $stable(faults))
  // A hit neither evicts nor counts a fault.
  `ASSERT_SAME(a_hit_clean, clk, rst, (state == ST_UPDATE) && dec_hit,
               !dec_evict && !dec_write && (dec_count == faults))
  // An update always leaves a result beat on the output.
  `ASSERT_NEXT(a_update_out, clk, rst, upd.en, m_tvalid)
  // A reported hit never carries an evicted page.
  `ASSERT_SAME(a_out_hit, clk, rst, m_tvalid && !m_tdata[0],
               !m_tdata[4] && (m_tdata[20:5] == 16'h0000))

endmodule

`default_nettype wire

// ===== rtl/core/lpr_cell.sv =====
// ---------------------------------------------------------------------------
// lpr_cell
// One page frame: holds page, valid and recency rank, joins the search chain.
// ---------------------------------------------------------------------------
`default_nettype none

module lpr_cell
  import lpr_pkg::*;
#(
  parameter int PAGE_BITS = 16,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 active,
  input  wire logic [PAGE_BITS-1:0] ref_page,
  input  wire srch_t                chain_in,
  input  wire logic [PAGE_BITS-1:0] worst_page_in,
  output srch_t                     chain_out,
  output logic      [PAGE_BITS-1:0] worst_page_out,
  input  wire upd_t                 upd,
  input  wire logic [PAGE_BITS-1:0] write_page
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [RANK_W-1:0]    rank;
  logic                 match;
  logic                 is_worst;

  assign match    = active && valid && (page == ref_page);
  assign is_worst = active && (rank >= chain_in.worst_rank);

  // Pass the search on: first hit, first empty frame, oldest (last on ties).
  always_comb begin
    chain_out      = chain_in;
    worst_page_out = worst_page_in;
    if (!chain_in.hit_found && match) begin
      chain_out.hit_found = 1'b1;
      chain_out.hit_idx   = MY_IDX;
      chain_out.hit_rank  = rank;
    end
    if (!chain_in.empty_found && active && !valid) begin
      chain_out.empty_found = 1'b1;
      chain_out.empty_idx   = MY_IDX;
    end
    if (is_worst) begin
      chain_out.worst_rank = rank;
      chain_out.worst_idx  = MY_IDX;
      worst_page_out       = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.clear) begin
        valid <= 1'b0;
        rank  <= '0;
      end else if (upd.slot == MY_IDX) begin
        rank <= '0;
        if (upd.write) begin
          valid <= 1'b1;
        end
      end else if (valid && ({1'b0, rank} < upd.limit)) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  // Page store has no reset; only read while valid.
  always_ff @(posedge clk) begin
    if (upd.en && !upd.clear && upd.write && (upd.slot == MY_IDX)) begin
      page <= write_page;
    end
  end

endmodule

`default_nettype wire

// ===== bench/lru_page_replacement_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_page_replacement_top_tb
// Drives page references into the LRU frame tracker and checks every result
// beat against a cycle-free prediction of the frame contents, recency order
// and fault count, across several frame-count settings.
// ---------------------------------------------------------------------------

module lru_page_replacement_top_tb;
  import lpr_pkg::*;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 6;    // settle time after the block drains
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 80;

  // Result fields, lowest bit first: fault, frame_index, evicted_valid,
  // evicted_page, fault_count.
  typedef struct packed {
    logic [31:0]          fault_count;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 evicted_valid;
    logic [2:0]           frame_index;
    logic                 fault;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [PAGE_BITS-1:0] s_tdata;     // page_number
  logic                 s_tlast;     // last_in_run
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;     // fault, frame_index[3], evicted_valid,
                                     // evicted_page[16], fault_count[32], pad
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;    // frames_in_use

  // Handshake knobs shared between the stimulus and the result sink.
  bit hold_output;
  bit sink_stalls;
  bit source_gaps;

  // -------------------------------------------------------------------------
  // Frame tracker prediction and the queue of outcomes still owed by the block
  // -------------------------------------------------------------------------
  class frame_scoreboard;
    logic [PAGE_BITS-1:0] page_in[MAX_FRAMES];
    bit                   occupied[MAX_FRAMES];
    int unsigned          age[MAX_FRAMES];
    logic [31:0]          fault_total;
    logic [CFG_W-1:0]     frames_reg;
    outcome_t             owed[$];
    int                   mismatch_count;

    function new();
      foreach (page_in[i]) page_in[i] = '0;
      clear_run();
      frames_reg     = 4'd4;
      mismatch_count = 0;
    endfunction

    function void clear_run();
      foreach (occupied[i]) begin
        occupied[i] = 1'b0;
        age[i]      = 0;
      end
      fault_total = '0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] value);
      frames_reg = value;
    endfunction

    // Zero acts as one frame, anything past the array acts as all of it.
    function int active_count();
      if (frames_reg == 0) return 1;
      if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
      return int'(frames_reg);
    endfunction

    // Move frame k to the front; valid frames younger than limit age by one.
    function void make_recent(int k, int unsigned limit);
      foreach (occupied[i]) begin
        if (i != k && occupied[i] && age[i] < limit) age[i]++;
      end
      age[k] = 0;
    endfunction

    function void note_reference(logic [PAGE_BITS-1:0] page, logic last);
      int          n;
      int          slot;
      int unsigned worst;
      bit          hit;
      bit          found_empty;
      outcome_t    res;
      n           = active_count();
      slot        = 0;
      hit         = 1'b0;
      found_empty = 1'b0;
      res         = '0;
      for (int i = 0; i < n; i++) begin
        if (!hit && occupied[i] && page_in[i] == page) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (hit) begin
        make_recent(slot, age[slot]);
      end else begin
        for (int i = 0; i < n; i++) begin
          if (!found_empty && !occupied[i]) begin
            slot        = i;
            found_empty = 1'b1;
          end
        end
        if (found_empty) begin
          page_in[slot]  = page;
          occupied[slot] = 1'b1;
          make_recent(slot, MAX_FRAMES);
        end else begin
          // Oldest active frame loses; ties go to the highest index.
          worst = 0;
          for (int i = 0; i < n; i++) begin
            if (age[i] >= worst) begin
              worst = age[i];
              slot  = i;
            end
          end
          res.evicted_valid = 1'b1;
          res.evicted_page  = page_in[slot];
          page_in[slot]     = page;
          make_recent(slot, worst);
        end
        if (fault_total != '1) fault_total++;
      end
      res.fault       = !hit;
      res.frame_index = 3'(slot);
      res.fault_count = fault_total;
      owed.push_back(res);
      if (last) clear_run();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
        mismatch_count++;
        return;
      end
      want = owed.pop_front();
      compare_field("fault",         want.fault,         got.fault);
      compare_field("frame_index",   want.frame_index,   got.frame_index);
      compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
      compare_field("evicted_page",  want.evicted_page,  got.evicted_page);
      compare_field("fault_count",   want.fault_count,   got.fault_count);
    endfunction

    function int waiting();
      return owed.size();
    endfunction
  endclass

  frame_scoreboard tracker;

  lru_page_replacement_top #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("lru_page_replacement_top_tb failed");
    $finish;
  end

  // Check every result beat taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_outcome(outcome_t'(m_tdata[52:0]));
  end

  // Result sink: change ready at falling edges. A hold request stalls the
  // output for a long stretch so the block backs up into its input.
  initial begin
    int stall_left;
    int pick;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_output = 1'b0;
      end else if (!sink_stalls) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          m_tready <= 1'b1;
        end else if (pick < 95) begin
          m_tready   <= 1'b0;
          stall_left = $urandom_range(2, 0);
        end else begin
          m_tready   <= 1'b0;
          stall_left = $urandom_range(40, 10);
        end
      end
    end
  end

  // Mostly back to back, some short gaps, the odd long one.
  function automatic int draw_gap();
    int pick;
    if (!source_gaps) return 0;
    pick = $urandom_range(99, 0);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // Drop valid between beats; n sets the length of the gap, and zero leaves none.
  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one reference and hold it until the block takes the beat.
  task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic last);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= page;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tracker.note_reference(page, last);
    idle_input(draw_gap());
  endtask

  task automatic wait_drained();
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  // Write the frame count only once the block has gone quiet.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    idle_input(1);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_frames(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PAGE_BITS-1:0] pool[$];
    logic [CFG_W-1:0]     setting;
    logic [PAGE_BITS-1:0] page;
    int                   pool_size;
    int                   pick;

    tracker     = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    hold_output = 1'b0;
    sink_stalls = 1'b0;
    source_gaps = 0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Default of four frames: fill, hit, evict the oldest, end the run.
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h0001, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h8000, 1'b0);
    send_reference(16'h0002, 1'b0);
    send_reference(16'h0000, 1'b1);

    sink_stalls = 1'b1;
    source_gaps = 1'b1;

    // Single frame, then a zero count that behaves as one frame.
    write_frames(4'd1);
    send_reference(16'h0005, 1'b0);
    send_reference(16'h0006, 1'b1);
    write_frames(4'd0);
    send_reference(16'h0007, 1'b0);
    send_reference(16'h0008, 1'b1);

    // Count past the array acts as all frames; the ninth page evicts.
    write_frames(4'd15);
    for (int i = 0; i < 9; i++) send_reference(16'h0010 + 16'(i), i == 8);

    // Lower the count mid-run: the upper frames keep their pages and are skipped,
    // and once the count is raised the lower copy of page 0103 takes the hit.
    write_frames(4'd8);
    for (int i = 0; i < 4; i++) send_reference(16'h0100 + 16'(i), 1'b0);
    write_frames(4'd2);
    send_reference(16'h0103, 1'b0);
    send_reference(16'h0101, 1'b0);
    write_frames(4'd8);
    send_reference(16'h0103, 1'b1);

    // Random phases: reuse a small pool of pages so hits and evictions both
    // show up, with some fully random references mixed in. Runs are left open
    // across phase boundaries unless a random last beat closes them.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = 4'd3;
        1: setting = 4'd8;
        2: setting = 4'd1;
        3: setting = 4'd15;
        4: setting = 4'd0;
        default: setting = CFG_W'($urandom_range(15, 0));
      endcase
      write_frames(setting);
      source_gaps = (ph % 4) != 0;
      sink_stalls = (ph % 4) != 0;

      pool_size = ((setting == 0) ? 1 : (setting > MAX_FRAMES) ? MAX_FRAMES : setting)
                  + $urandom_range(3, 0);
      pool.delete();
      for (int i = 0; i < pool_size; i++) pool.push_back(PAGE_BITS'($urandom));

      // Stall the output for a long stretch while references keep coming.
      if (ph == 1) hold_output = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Pause the source until the block has answered everything.
        if (ph == 5 && k == PHASE_ITEMS / 2) begin
          idle_input(1);
          wait_drained();
        end
        pick = $urandom_range(99, 0);
        if (pick < 85) page = pool[$urandom_range(pool_size - 1, 0)];
        else page = PAGE_BITS'($urandom);
        send_reference(page, $urandom_range(29, 0) == 0);
      end
    end

    // Drain, then keep watching for any stray beat before the verdict.
    idle_input(1);
    wait_drained();
    repeat (SETTLE * 4) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.waiting() == 0) begin
      $display("lru_page_replacement_top_tb passed");
    end else begin
      $display("lru_page_replacement_top_tb failed");
    end
    $finish;
  end

endmodule
